[hw/rtl/gcr62_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcr62_pkg;

  // Field marks and sync words of the track layout
  localparam logic [23:0] SYNC_A        = 24'hff3fcf;
  localparam logic [23:0] SYNC_B        = 24'hf3fcff;
  localparam logic [23:0] ADDR_PROLOGUE = 24'hd5aa96;
  localparam logic [23:0] ADDR_EPILOGUE = 24'hdeaaff;
  localparam logic [23:0] DATA_PROLOGUE = 24'hd5aaad;
  localparam logic [31:0] DATA_EPILOGUE = 32'hdeaaffff;

  localparam logic        OP_HEADER  = 1'b0;
  localparam logic [5:0]  FORMAT_RST = 6'd34;

  // Register addresses
  localparam logic        REG_FORMAT = 1'b0;

  // Bit counts of a result
  localparam logic [5:0]  BC_NIBBLE = 6'd8;
  localparam logic [5:0]  BC_MARK   = 6'd24;
  localparam logic [5:0]  BC_WORD   = 6'd32;

  // Result sequence of a header item (0 to 15 are the alternating sync pairs)
  localparam int          IDX_W         = 5;
  localparam logic [4:0]  IDX_PROLOGUE  = 5'd16;
  localparam logic [4:0]  IDX_TRK       = 5'd17;
  localparam logic [4:0]  IDX_SEC       = 5'd18;
  localparam logic [4:0]  IDX_SIDE      = 5'd19;
  localparam logic [4:0]  IDX_FMT       = 5'd20;
  localparam logic [4:0]  IDX_CHK       = 5'd21;
  localparam logic [4:0]  IDX_EPILOGUE  = 5'd22;
  localparam logic [4:0]  IDX_SYNC_A2   = 5'd23;
  localparam logic [4:0]  IDX_SYNC_B2   = 5'd24;
  localparam logic [4:0]  IDX_DPROLOGUE = 5'd25;
  localparam logic [4:0]  IDX_DSEC      = 5'd26;

  // Result sequence of a data item
  localparam logic [4:0]  IDX_GROUP     = 5'd0;
  localparam logic [4:0]  IDX_CSUM      = 5'd1;
  localparam logic [4:0]  IDX_DEPILOGUE = 5'd2;

  typedef struct packed {
    logic clear;
    logic step;
    logic last;
  } csum_ctl_t;

  function automatic logic [7:0] gcr_code(input logic [5:0] v);
    logic [7:0] c;
    case (v)
      6'd0:  c = 8'h96;  6'd1:  c = 8'h97;  6'd2:  c = 8'h9a;  6'd3:  c = 8'h9b;
      6'd4:  c = 8'h9d;  6'd5:  c = 8'h9e;  6'd6:  c = 8'h9f;  6'd7:  c = 8'ha6;
      6'd8:  c = 8'ha7;  6'd9:  c = 8'hab;  6'd10: c = 8'hac;  6'd11: c = 8'had;
      6'd12: c = 8'hae;  6'd13: c = 8'haf;  6'd14: c = 8'hb2;  6'd15: c = 8'hb3;
      6'd16: c = 8'hb4;  6'd17: c = 8'hb5;  6'd18: c = 8'hb6;  6'd19: c = 8'hb7;
      6'd20: c = 8'hb9;  6'd21: c = 8'hba;  6'd22: c = 8'hbb;  6'd23: c = 8'hbc;
      6'd24: c = 8'hbd;  6'd25: c = 8'hbe;  6'd26: c = 8'hbf;  6'd27: c = 8'hcb;
      6'd28: c = 8'hcd;  6'd29: c = 8'hce;  6'd30: c = 8'hcf;  6'd31: c = 8'hd3;
      6'd32: c = 8'hd6;  6'd33: c = 8'hd7;  6'd34: c = 8'hd9;  6'd35: c = 8'hda;
      6'd36: c = 8'hdb;  6'd37: c = 8'hdc;  6'd38: c = 8'hdd;  6'd39: c = 8'hde;
      6'd40: c = 8'hdf;  6'd41: c = 8'he5;  6'd42: c = 8'he6;  6'd43: c = 8'he7;
      6'd44: c = 8'he9;  6'd45: c = 8'hea;  6'd46: c = 8'heb;  6'd47: c = 8'hec;
      6'd48: c = 8'hed;  6'd49: c = 8'hee;  6'd50: c = 8'hef;  6'd51: c = 8'hf2;
      6'd52: c = 8'hf3;  6'd53: c = 8'hf4;  6'd54: c = 8'hf5;  6'd55: c = 8'hf6;
      6'd56: c = 8'hf7;  6'd57: c = 8'hf9;  6'd58: c = 8'hfa;  6'd59: c = 8'hfb;
      6'd60: c = 8'hfc;  6'd61: c = 8'hfd;  6'd62: c = 8'hfe;  6'd63: c = 8'hff;
      default: c = 8'h96;
    endcase
    return c;
  endfunction

  // Three bytes become four nibbles: the top two bits of each byte are
  // gathered into a leading nibble.
  function automatic logic [31:0] word_of(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [5:0] hi;
    hi = {a[7:6], b[7:6], c[7:6]};
    return {gcr_code(hi), gcr_code(a[5:0]), gcr_code(b[5:0]), gcr_code(c[5:0])};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gcr62_csum.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcr62_csum import gcr62_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire csum_ctl_t   ctl,
  input  wire logic [7:0]  byte_a,
  input  wire logic [7:0]  byte_b,
  input  wire logic [7:0]  byte_c,
  output logic      [31:0] data_word,
  output logic      [31:0] sum_word
);

  logic [7:0] sum_a_r, sum_b_r, sum_c_r;
  logic [7:0] sum_a_nxt, sum_b_nxt, sum_c_nxt;
  logic [7:0] rot_c, vc, wa, wb, wc;
  logic [8:0] add_a, add_b;

  always_comb begin
    rot_c     = {sum_c_r[6:0], sum_c_r[7]};
    vc        = ctl.last ? 8'd0 : byte_c;
    add_a     = {1'b0, sum_a_r} + {1'b0, byte_a} + {8'd0, rot_c[0]};
    add_b     = {1'b0, sum_b_r} + {1'b0, byte_b} + {8'd0, add_a[8]};
    sum_a_nxt = add_a[7:0];
    sum_b_nxt = add_b[7:0];
    // The third sum only takes a byte when the group is a full one.
    sum_c_nxt = ctl.last ? rot_c : (rot_c + vc + {7'd0, add_b[8]});
    wa        = byte_a ^ rot_c;
    wb        = byte_b ^ sum_a_nxt;
    wc        = vc ^ sum_b_nxt;
    data_word = word_of(wa, wb, wc);
    sum_word  = word_of(sum_a_nxt, sum_b_nxt, sum_c_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      sum_c_r <= 8'd0;
    end else if (ctl.step) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      sum_c_r <= sum_c_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gcr62_sector_encoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// An accepted item is loaded into the item register, and its result words pass
// through the output register. A data group gives one result word (a last
// group three) and a header item gives 27. The result sequencer sends one word
// per cycle unless the output stalls, so groups can follow back to back.
// Reset clears the checksum, the sequencer and the output register and sets
// the format register to 34.
module gcr62_sector_encoder_top import gcr62_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [6:0]  in_track_number,
  input  wire logic [5:0]  in_sector_number,
  input  wire logic        in_head_side,
  input  wire logic [7:0]  in_byte_a,
  input  wire logic [7:0]  in_byte_b,
  input  wire logic [7:0]  in_byte_c,
  input  wire logic        in_last_group,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_code_bits,
  output logic      [5:0]  out_bit_count,
  output logic             out_last_result,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [5:0]       fmt_r;
  logic             busy_r, hdr_r, last_r;
  logic [IDX_W-1:0] idx_r, fin_r;
  logic [31:0]      word_r, sum_r;
  logic [7:0]       c_trk_r, c_sec_r, c_side_r, c_fmt_r, c_chk_r;
  logic             out_valid_r, out_last_r;
  logic [31:0]      out_bits_r;
  logic [5:0]       out_count_r;

  logic             accept, emit, emit_last, cfg_wr;
  logic             is_hdr;
  logic [5:0]       side, chk;
  logic [31:0]      data_word, sum_word;
  logic [31:0]      bits_nxt;
  logic [5:0]       count_nxt;
  csum_ctl_t        ctl;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_FORMAT);
  assign cfg_prdata = (cfg_paddr[2] == REG_FORMAT) ? {26'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FORMAT_RST;
    end else if (cfg_wr) begin
      fmt_r <= cfg_pwdata[5:0];
    end
  end

  // The item register frees up in the cycle its final word moves on.
  assign emit      = busy_r && (!out_valid_r || !out_stall);
  assign emit_last = emit && (idx_r == fin_r);
  assign in_stall  = busy_r && !emit_last;
  assign accept    = in_valid && !in_stall;
  assign is_hdr    = (in_op == OP_HEADER);

  assign side = {in_head_side, 4'd0, in_track_number[6]};
  assign chk  = in_track_number[5:0] ^ in_sector_number ^ side ^ fmt_r;

  assign ctl.clear = accept && is_hdr;
  assign ctl.step  = accept && !is_hdr;
  assign ctl.last  = in_last_group;

  gcr62_csum u_csum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .byte_a    (in_byte_a),
    .byte_b    (in_byte_b),
    .byte_c    (in_byte_c),
    .data_word (data_word),
    .sum_word  (sum_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (emit_last) begin
      busy_r <= 1'b0;
    end else if (emit) begin
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r    <= is_hdr;
      last_r   <= in_last_group;
      fin_r    <= is_hdr ? IDX_DSEC : (in_last_group ? IDX_DEPILOGUE : IDX_GROUP);
      word_r   <= data_word;
      sum_r    <= sum_word;
      c_trk_r  <= gcr_code(in_track_number[5:0]);
      c_sec_r  <= gcr_code(in_sector_number);
      c_side_r <= gcr_code(side);
      c_fmt_r  <= gcr_code(fmt_r);
      c_chk_r  <= gcr_code(chk);
    end
  end

  always_comb begin
    bits_nxt  = DATA_EPILOGUE;
    count_nxt = BC_WORD;
    if (hdr_r) begin
      count_nxt = BC_NIBBLE;
      case (idx_r)
        IDX_PROLOGUE:  begin bits_nxt = {8'd0, ADDR_PROLOGUE}; count_nxt = BC_MARK; end
        IDX_TRK:       bits_nxt = {24'd0, c_trk_r};
        IDX_SEC:       bits_nxt = {24'd0, c_sec_r};
        IDX_SIDE:      bits_nxt = {24'd0, c_side_r};
        IDX_FMT:       bits_nxt = {24'd0, c_fmt_r};
        IDX_CHK:       bits_nxt = {24'd0, c_chk_r};
        IDX_EPILOGUE:  begin bits_nxt = {8'd0, ADDR_EPILOGUE}; count_nxt = BC_MARK; end
        IDX_SYNC_A2:   begin bits_nxt = {8'd0, SYNC_A}; count_nxt = BC_MARK; end
        IDX_SYNC_B2:   begin bits_nxt = {8'd0, SYNC_B}; count_nxt = BC_MARK; end
        IDX_DPROLOGUE: begin bits_nxt = {8'd0, DATA_PROLOGUE}; count_nxt = BC_MARK; end
        IDX_DSEC:      bits_nxt = {24'd0, c_sec_r};
        default: begin
          // The leading sync pairs alternate between the two words.
          bits_nxt  = idx_r[0] ? {8'd0, SYNC_B} : {8'd0, SYNC_A};
          count_nxt = BC_MARK;
        end
      endcase
    end else begin
      case (idx_r)
        IDX_GROUP: begin
          if (last_r) begin
            bits_nxt  = {8'd0, word_r[31:8]};
            count_nxt = BC_MARK;
          end else begin
            bits_nxt  = word_r;
          end
        end
        IDX_CSUM:  bits_nxt = sum_r;
        default:   bits_nxt = DATA_EPILOGUE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bits_r  <= bits_nxt;
      out_count_r <= count_nxt;
      out_last_r  <= (idx_r == fin_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_bits   = out_bits_r;
  assign out_bit_count   = out_count_r;
  assign out_last_result = out_last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("item register not loaded after an accepted item");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= fin_r))
    else $error("result index ran past the final result of the item");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == BC_NIBBLE || out_count_r == BC_MARK ||
                     out_count_r == BC_WORD))
    else $error("result carries an illegal bit count");

  a_hdr_final: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_hdr) |=> (fin_r == IDX_DSEC && idx_r == '0))
    else $error("header item did not start a full header sequence");

endmodule

`default_nettype wire

[bench/gcr62_sector_encoder_top_test.sv]
`timescale 1ns / 1ps

module gcr62_sector_encoder_top_test;
  import gcr62_pkg::*;

  localparam logic       OP_GROUP           = ~OP_HEADER;
  localparam logic [2:0] FORMAT_ADDR        = 3'(4 * REG_FORMAT);
  localparam int         IDLE_LIMIT         = 2000;
  localparam int         LONG_HOLD          = 400;
  localparam int         ITEMS_PER_PHASE    = 60;
  localparam int         PHASES             = 6;
  localparam int         FULL_SECTOR_GROUPS = 174;
  localparam int         SETTLE_CYCLES      = 10;
  localparam int         DIRECTED_ROWS      = 20;

  typedef struct packed {
    logic       op;
    logic [6:0] track_number;
    logic [5:0] sector_number;
    logic       head_side;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic       last_group;
  } sector_item_t;

  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  bit_count;
    logic        last_result;
  } code_word_t;

  typedef struct packed {
    sector_item_t item;
    logic         typed;
    logic [31:0]  final_bits;
    logic [5:0]   final_count;
  } directed_row_t;

  localparam logic [7:0] NIBBLE_CODE [64] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  // Where typed, the final word of the item is given directly; the rest come from the predictor.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // op        trk     sec    side  a      b      c      last    typed  final word     count
    '{'{OP_HEADER, 7'd0,   6'd0,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 32'h0000_0096, BC_NIBBLE},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 32'h9696_9696, BC_WORD},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h80, 8'h55, 8'haa, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD},
    '{'{OP_HEADER, 7'd127, 6'd63, 1'b1, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, 32'h0000_00ff, BC_NIBBLE},
    '{'{OP_GROUP,  7'd127, 6'd63, 1'b1, 8'h01, 8'h02, 8'h03, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'hfe, 8'hfd, 8'hfc, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h00, 8'h00, 8'hff, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'hff, 8'h00, 8'hff, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h00, 8'hff, 8'h00, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD},
    '{'{OP_HEADER, 7'd64,  6'd1,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 32'h0000_0097, BC_NIBBLE},
    '{'{OP_HEADER, 7'd63,  6'd32, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 32'h0000_00d6, BC_NIBBLE},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h7f, 8'h7f, 8'h7f, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h40, 8'hc0, 8'h3f, 1'b0}, 1'b0, 32'h0,         6'd0},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'ha5, 8'h5a, 8'hc3, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD},
    '{'{OP_HEADER, 7'd5,   6'd9,  1'b0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, 32'h0000_00ab, BC_NIBBLE},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD},
    '{'{OP_HEADER, 7'd1,   6'd62, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 32'h0000_00fe, BC_NIBBLE},
    '{'{OP_GROUP,  7'd0,   6'd0,  1'b0, 8'hff, 8'hff, 8'h00, 1'b1}, 1'b1, DATA_EPILOGUE, BC_WORD}
  };

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  sector_item_t offer;
  logic         out_valid;
  logic         out_stall;
  logic [31:0]  out_code_bits;
  logic [5:0]   out_bit_count;
  logic         out_last_result;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic         typed_valid;
  logic [31:0]  typed_bits;
  logic [5:0]   typed_count;
  logic         eager = 1'b0;
  logic         hold_long = 1'b0;

  logic [5:0]   format_shadow = FORMAT_RST;
  logic [7:0]   csum_a = 8'h00;
  logic [7:0]   csum_b = 8'h00;
  logic [7:0]   csum_c = 8'h00;
  code_word_t   expected_words [$];

  int failures        = 0;
  int items_sent      = 0;
  int items_taken     = 0;
  int headers_taken   = 0;
  int sectors_closed  = 0;
  int results_checked = 0;
  int formats_used    = 0;
  int idle_cycles     = 0;

  gcr62_sector_encoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (offer.op),
    .in_track_number (offer.track_number),
    .in_sector_number(offer.sector_number),
    .in_head_side    (offer.head_side),
    .in_byte_a       (offer.byte_a),
    .in_byte_b       (offer.byte_b),
    .in_byte_c       (offer.byte_c),
    .in_last_group   (offer.last_group),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_bits   (out_code_bits),
    .out_bit_count   (out_bit_count),
    .out_last_result (out_last_result),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] pack_group(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    return {NIBBLE_CODE[{a[7:6], b[7:6], c[7:6]}], NIBBLE_CODE[a[5:0]],
            NIBBLE_CODE[b[5:0]], NIBBLE_CODE[c[5:0]]};
  endfunction

  function automatic void queue_word(input logic [31:0] bits, input logic [5:0] count,
                                     input logic last);
    code_word_t w;
    w.code_bits   = bits;
    w.bit_count   = count;
    w.last_result = last;
    expected_words.push_back(w);
  endfunction

  function automatic void encode_item(input sector_item_t it);
    logic [5:0] side_val;
    logic [5:0] check_val;
    logic [8:0] carry_a;
    logic [8:0] carry_b;
    logic [7:0] wa;
    logic [7:0] wb;
    logic [7:0] wc;
    if (it.op == OP_HEADER) begin
      side_val  = {it.head_side, 4'b0000, it.track_number[6]};
      check_val = it.track_number[5:0] ^ it.sector_number ^ side_val ^ format_shadow;
      for (int i = 0; i < 8; i++) begin
        queue_word({8'd0, SYNC_A}, BC_MARK, 1'b0);
        queue_word({8'd0, SYNC_B}, BC_MARK, 1'b0);
      end
      queue_word({8'd0, ADDR_PROLOGUE}, BC_MARK, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[it.track_number[5:0]]}, BC_NIBBLE, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[it.sector_number]}, BC_NIBBLE, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[side_val]}, BC_NIBBLE, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[format_shadow]}, BC_NIBBLE, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[check_val]}, BC_NIBBLE, 1'b0);
      queue_word({8'd0, ADDR_EPILOGUE}, BC_MARK, 1'b0);
      queue_word({8'd0, SYNC_A}, BC_MARK, 1'b0);
      queue_word({8'd0, SYNC_B}, BC_MARK, 1'b0);
      queue_word({8'd0, DATA_PROLOGUE}, BC_MARK, 1'b0);
      queue_word({24'd0, NIBBLE_CODE[it.sector_number]}, BC_NIBBLE, 1'b1);
      csum_a = 8'h00;
      csum_b = 8'h00;
      csum_c = 8'h00;
    end else begin
      // The closing group has only two bytes, so its third byte counts as zero.
      wc      = it.last_group ? 8'h00 : it.byte_c;
      csum_c  = {csum_c[6:0], csum_c[7]};
      carry_a = {1'b0, csum_a} + {1'b0, it.byte_a} + {8'd0, csum_c[0]};
      csum_a  = carry_a[7:0];
      wa      = it.byte_a ^ csum_c;
      carry_b = {1'b0, csum_b} + {1'b0, it.byte_b} + {8'd0, carry_a[8]};
      csum_b  = carry_b[7:0];
      wb      = it.byte_b ^ csum_a;
      if (!it.last_group) csum_c = csum_c + wc + {7'd0, carry_b[8]};
      wc      = wc ^ csum_b;
      if (!it.last_group) begin
        queue_word(pack_group(wa, wb, wc), BC_WORD, 1'b1);
      end else begin
        queue_word(pack_group(wa, wb, wc) >> 8, BC_MARK, 1'b0);
        queue_word(pack_group(csum_a, csum_b, csum_c), BC_WORD, 1'b0);
        queue_word(DATA_EPILOGUE, BC_WORD, 1'b1);
      end
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sector_item_t random_item(input logic op, input logic last);
    logic [63:0]  bits;
    sector_item_t it;
    bits          = {$urandom, $urandom};
    it            = bits[39:0];
    it.op         = op;
    it.last_group = last;
    return it;
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(input sector_item_t it, input logic typed,
                           input logic [31:0] fbits, input logic [5:0] fcount);
    int gap;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    offer       = it;
    typed_valid = typed;
    typed_bits  = fbits;
    typed_count = fcount;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_sector(input int groups);
    send_item(random_item(OP_HEADER, 1'($urandom)), 1'b0, '0, '0);
    repeat (groups) send_item(random_item(OP_GROUP, 1'b0), 1'b0, '0, '0);
    send_item(random_item(OP_GROUP, 1'b1), 1'b0, '0, '0);
  endtask

  task automatic await_drain();
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Writes the format register, then reads it back.
  task automatic set_format(input logic [5:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = FORMAT_ADDR;
    cfg_pwdata  = {26'($urandom), value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {26'd0, value}) begin
      $error("cfg_prdata: expected %h, got %h", {26'd0, value}, cfg_prdata);
      failures++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    formats_used++;
  endtask

  always @(posedge clk) begin : scoreboard
    code_word_t want;
    logic       progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == FORMAT_ADDR) format_shadow = cfg_pwdata[5:0];
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        encode_item(offer);
        if (typed_valid) begin
          want                = expected_words[$];
          want.code_bits      = typed_bits;
          want.bit_count      = typed_count;
          expected_words[$]   = want;
        end
        items_taken++;
        if (offer.op == OP_HEADER) headers_taken++;
        else if (offer.last_group) sectors_closed++;
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        results_checked++;
        if (expected_words.size() == 0) begin
          $error("unexpected result: code_bits %h, bit_count %0d, last_result %b",
                 out_code_bits, out_bit_count, out_last_result);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (out_code_bits !== want.code_bits) begin
            $error("out_code_bits: expected %h, got %h", want.code_bits, out_code_bits);
            failures++;
          end
          if (out_bit_count !== want.bit_count) begin
            $error("out_bit_count: expected %0d, got %0d", want.bit_count, out_bit_count);
            failures++;
          end
          if (out_last_result !== want.last_result) begin
            $error("out_last_result: expected %b, got %b", want.last_result, out_last_result);
            failures++;
          end
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out after %0d idle cycles with %0d code words outstanding.",
                 idle_cycles, expected_words.size());
        $display("gcr62_sector_encoder_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : receiver
    int free_run;
    int stall_left;
    out_stall  = 1'b0;
    free_run   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
      end else if (free_run > 0) begin
        out_stall = 1'b0;
        free_run--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        free_run   = $urandom_range(0, 40);
        stall_left = pick_gap();
        out_stall  = 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         phase_start;
    int         pick;
    int         groups;
    logic [5:0] fmt;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    offer       = '0;
    typed_valid = 1'b0;
    typed_bits  = '0;
    typed_count = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].final_bits,
                DIRECTED[r].final_count);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      await_drain();
      case (phase)
        0:       fmt = 6'd0;
        1:       fmt = 6'd63;
        PHASES - 1: fmt = FORMAT_RST;
        default: fmt = 6'($urandom);
      endcase
      set_format(fmt);
      phase_start = items_sent;
      if (phase == 1) begin
        // A full sector streams in back to back while the receiver holds off,
        // so the block fills up and has to stall its input.
        hold_long = 1'b1;
        eager     = 1'b1;
        send_sector(FULL_SECTOR_GROUPS);
      end
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        pick  = $urandom_range(0, 99);
        eager = ($urandom_range(0, 3) == 0);
        if (pick < 70) begin
          groups = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
          send_sector(groups);
        end else if (pick < 85) begin
          // Stray groups carry the checksum on from wherever it stands.
          groups = $urandom_range(1, 6);
          repeat (groups) begin
            send_item(random_item(OP_GROUP, $urandom_range(0, 3) == 0), 1'b0, '0, '0);
          end
        end else begin
          send_item(random_item(OP_HEADER, 1'($urandom)), 1'b0, '0, '0);
        end
      end
      eager = 1'b0;
    end

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d code words from %0d items: %0d headers, %0d closing groups.",
             results_checked, items_taken, headers_taken, sectors_closed);
    $display("Format register set %0d times, both extremes included; one full sector ran %s",
             formats_used, "under a long output hold-off.");
    if (failures == 0) begin
      $display("gcr62_sector_encoder_top: match");
    end else begin
      $display("gcr62_sector_encoder_top: mismatch");
    end
    $finish;
  end

endmodule
